FILE: rtl/sca_pkg.sv
`timescale 1ns / 1ps

package sca_pkg;

  localparam int OP_W       = 3;
  localparam int CELL_IDX_W = 10;
  localparam int VAL_W      = 16;
  localparam int CNT_W      = 16;
  localparam int CFG_W      = 5;

  localparam logic [OP_W-1:0] OP_INC   = 3'd0;
  localparam logic [OP_W-1:0] OP_DEC   = 3'd1;
  localparam logic [OP_W-1:0] OP_READ  = 3'd2;
  localparam logic [OP_W-1:0] OP_SET   = 3'd3;
  localparam logic [OP_W-1:0] OP_CLEAR = 3'd4;

  localparam logic [CFG_W-1:0] WIDTH_RESET = 5'd4;

endpackage

FILE: rtl/sca_if.sv
`timescale 1ns / 1ps

interface sca_in_if;
  import sca_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [OP_W-1:0]       opcode;
  logic [CELL_IDX_W-1:0] cell_index;
  logic [VAL_W-1:0]      operand_value;

  modport source (output valid, output opcode, output cell_index, output operand_value,
                  input ready);
  modport sink (input valid, input opcode, input cell_index, input operand_value,
                output ready);
endinterface

interface sca_out_if;
  import sca_pkg::*;

  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] count_out;
  logic             ok;

  modport source (output valid, output count_out, output ok, input ready);
  modport sink (input valid, input count_out, input ok, output ready);
endinterface

FILE: rtl/saturating_counter_array.sv
`timescale 1ns / 1ps

// Array of NUM_CELLS saturating counters held in one single-port synchronous memory.
// Increment, decrement, read and set: the accepting edge reads the cell; in the modify
// state, once the result register is free, the new count is written back to an in-range
// cell and the result register loaded; only then is the next request taken. The result
// register frees the input side while a result waits to be taken. Clear walks the memory
// one cell per cycle, then its result waits for a free result register. After reset the
// same clearing pass runs with no result; no request is accepted during it, while
// configuration writes are. The cfg port sets the counter width, read in the modify state.
module saturating_counter_array #(
  parameter int NUM_CELLS = 1024,
  parameter int MAX_WIDTH = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic [sca_pkg::CFG_W-1:0]   cfg_wr_data,
  sca_in_if.sink                      in_req,
  sca_out_if.source                   out_rsp
);
  import sca_pkg::*;

  localparam int ADDR_W = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;
  localparam int IDX_W  = 17;
  localparam int AW     = (MAX_WIDTH > VAL_W) ? MAX_WIDTH : VAL_W;
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(NUM_CELLS - 1);

  typedef enum logic [3:0] {
    S_CLEAR  = 4'b0001,
    S_IDLE   = 4'b0010,
    S_MODIFY = 4'b0100,
    S_FINISH = 4'b1000
  } state_t;

  state_t                state_r, state_nxt;
  logic [ADDR_W-1:0]     clr_addr_r, clr_addr_nxt;
  logic                  clr_resp_r, clr_resp_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [CNT_W-1:0]      out_count_r;
  logic                  out_ok_r;
  logic [CFG_W-1:0]      cfg_width_r;

  logic [OP_W-1:0]       op_r;
  logic [VAL_W-1:0]      val_r;
  logic [ADDR_W-1:0]     addr_r;
  logic                  hit_r;

  logic [MAX_WIDTH-1:0]  mem [NUM_CELLS];
  logic [MAX_WIDTH-1:0]  rd_data_r;

  logic                  accept;
  logic                  out_free;
  logic                  load_out;
  logic [CNT_W-1:0]      load_count;
  logic                  load_ok;
  logic                  wr_en;
  logic [ADDR_W-1:0]     wr_addr;
  logic [MAX_WIDTH-1:0]  wr_data;
  logic [IDX_W-1:0]      in_idx;
  logic                  in_hit;

  logic [7:0]            w_eff;
  logic [7:0]            shamt;
  logic [MAX_WIDTH-1:0]  maxv_s;
  logic [AW-1:0]         maxv;
  logic [AW-1:0]         old_v;
  logic [AW-1:0]         val_v;
  logic [AW-1:0]         nv;
  logic                  nv_ok;

  assign in_req.ready    = (state_r == S_IDLE);
  assign accept          = in_req.valid && (state_r == S_IDLE);
  assign out_rsp.valid   = out_valid_r;
  assign out_rsp.count_out = out_count_r;
  assign out_rsp.ok      = out_ok_r;
  assign out_free        = !out_valid_r || out_rsp.ready;

  assign in_idx = IDX_W'(in_req.cell_index);
  assign in_hit = (in_idx < IDX_W'(NUM_CELLS)) &&
                  (in_req.opcode inside {[OP_INC:OP_SET]});

  always_comb begin
    if (cfg_width_r == '0) begin
      w_eff = 8'd1;
    end else if (8'(cfg_width_r) > 8'(MAX_WIDTH)) begin
      w_eff = 8'(MAX_WIDTH);
    end else begin
      w_eff = 8'(cfg_width_r);
    end
    shamt  = 8'(MAX_WIDTH) - w_eff;
    maxv_s = {MAX_WIDTH{1'b1}} >> shamt;
    maxv   = AW'(maxv_s);
  end

  always_comb begin
    old_v = AW'(rd_data_r) & maxv;
    val_v = AW'(val_r);
    nv    = old_v;
    nv_ok = 1'b0;
    case (op_r)
      OP_INC: begin
        if (val_v >= maxv) begin
          nv    = maxv;
          nv_ok = (old_v < maxv);
        end else if (old_v > maxv - val_v) begin
          nv    = maxv;
          nv_ok = 1'b0;
        end else begin
          nv    = old_v + val_v;
          nv_ok = 1'b1;
        end
      end
      OP_DEC: begin
        if (old_v != '0) begin
          nv    = old_v - AW'(1);
          nv_ok = 1'b1;
        end
      end
      OP_READ: begin
        nv_ok = 1'b1;
      end
      OP_SET: begin
        if (val_v > maxv) begin
          nv    = maxv;
          nv_ok = 1'b0;
        end else begin
          nv    = val_v;
          nv_ok = 1'b1;
        end
      end
      default: begin
        nv    = '0;
        nv_ok = 1'b0;
      end
    endcase
    if (!hit_r) begin
      nv    = '0;
      nv_ok = 1'b0;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    clr_addr_nxt  = clr_addr_r;
    clr_resp_nxt  = clr_resp_r;
    load_out      = 1'b0;
    load_count    = '0;
    load_ok       = 1'b0;
    wr_en         = 1'b0;
    wr_addr       = addr_r;
    wr_data       = nv[MAX_WIDTH-1:0];
    case (state_r)
      S_CLEAR: begin
        wr_en        = 1'b1;
        wr_addr      = clr_addr_r;
        wr_data      = '0;
        clr_addr_nxt = clr_addr_r + ADDR_W'(1);
        if (clr_addr_r == LAST_ADDR) begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!clr_resp_r) begin
          state_nxt = S_IDLE;
        end else if (out_free) begin
          load_out     = 1'b1;
          load_ok      = 1'b1;
          clr_resp_nxt = 1'b0;
          state_nxt    = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          if (in_req.opcode == OP_CLEAR) begin
            clr_addr_nxt = '0;
            clr_resp_nxt = 1'b1;
            state_nxt    = S_CLEAR;
          end else begin
            state_nxt = S_MODIFY;
          end
        end
      end
      S_MODIFY: begin
        if (out_free) begin
          load_out   = 1'b1;
          load_count = nv[CNT_W-1:0];
          load_ok    = nv_ok;
          wr_en      = hit_r;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    out_valid_nxt = load_out || (out_valid_r && !out_rsp.ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_addr_r  <= '0;
      clr_resp_r  <= 1'b0;
      out_valid_r <= 1'b0;
      cfg_width_r <= WIDTH_RESET;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      clr_resp_r  <= clr_resp_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        cfg_width_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r   <= in_req.opcode;
      val_r  <= in_req.operand_value;
      addr_r <= in_idx[ADDR_W-1:0];
      hit_r  <= in_hit;
    end
    if (load_out) begin
      out_count_r <= load_count;
      out_ok_r    <= load_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (accept) begin
      rd_data_r <= mem[in_idx[ADDR_W-1:0]];
    end
  end

  a_accept_moves_on: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == S_MODIFY || state_r == S_CLEAR))
    else $error("accepted request did not start a read or a clearing pass");

  a_clear_walks: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |=> (state_r == S_CLEAR || state_r == S_FINISH))
    else $error("clearing pass left early");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_MODIFY || state_r == S_FINISH))
    else $error("result loaded outside modify or finish");

  a_result_fits: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((AW'(out_count_r) & ~maxv) == '0))
    else $error("result exceeds the counter maximum");

endmodule

FILE: dv/saturating_counter_array_test.sv
`timescale 1ns / 1ps

module saturating_counter_array_test;
  import sca_pkg::*;

  localparam int NUM_CELLS = 1024;
  localparam int MAX_WIDTH = 16;
  localparam int PHASE_REQS = 184;
  localparam int HOLD_AT_REQ = 150;
  localparam int HOLD_CYCLES = 400;
  localparam int MAX_REPORTS = 64;

  localparam logic [OP_W-1:0] OP_RSVD5 = 3'd5;
  localparam logic [OP_W-1:0] OP_RSVD6 = 3'd6;
  localparam logic [OP_W-1:0] OP_RSVD7 = 3'd7;

  typedef struct packed {
    logic [OP_W-1:0]       opcode;
    logic [CELL_IDX_W-1:0] cell_index;
    logic [VAL_W-1:0]      operand_value;
  } counter_req_t;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic             ok;
  } counter_rsp_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_wr_en;
  logic [CFG_W-1:0] cfg_wr_data;

  sca_in_if  in_if ();
  sca_out_if out_if ();

  saturating_counter_array #(
    .NUM_CELLS(NUM_CELLS),
    .MAX_WIDTH(MAX_WIDTH)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_req     (in_if),
    .out_rsp    (out_if)
  );

  counter_req_t     request_queue[$];
  counter_rsp_t     predicted_rsps[$];
  logic [CNT_W-1:0] shadow_cells[NUM_CELLS];
  logic [CFG_W-1:0] width_setting = WIDTH_RESET;
  int               tx_idle_pct = 26;
  int               rx_idle_pct = 83;
  int               accepted_reqs = 0;
  int               hold_left;
  logic             hold_done;
  int               errors = 0;

  always #5 clk = ~clk;

  function automatic logic [CNT_W-1:0] width_max(logic [CFG_W-1:0] w);
    int ew;
    ew = w;
    if (ew < 1) ew = 1;
    if (ew > MAX_WIDTH) ew = MAX_WIDTH;
    return CNT_W'((33'd1 << ew) - 1);
  endfunction

  function automatic counter_rsp_t apply_counter_op(counter_req_t r);
    counter_rsp_t     rsp;
    logic [CNT_W-1:0] maxv;
    logic [CNT_W-1:0] old;
    logic [CNT_W-1:0] nv;
    maxv = width_max(width_setting);
    rsp = '0;
    if (r.opcode == OP_CLEAR) begin
      foreach (shadow_cells[i]) shadow_cells[i] = '0;
      rsp.ok = 1'b1;
      return rsp;
    end
    if (r.opcode > OP_SET || r.cell_index >= NUM_CELLS) return rsp;
    old = shadow_cells[r.cell_index] & maxv;
    nv = old;
    case (r.opcode)
      OP_INC: begin
        if (r.operand_value >= maxv) begin
          nv = maxv;
          rsp.ok = (old < maxv);
        end else if (old > maxv - r.operand_value) begin
          nv = maxv;
        end else begin
          nv = old + r.operand_value;
          rsp.ok = 1'b1;
        end
      end
      OP_DEC: begin
        if (old != 0) begin
          nv = old - 1'b1;
          rsp.ok = 1'b1;
        end
      end
      OP_READ: rsp.ok = 1'b1;
      default: begin
        if (r.operand_value > maxv) begin
          nv = maxv;
        end else begin
          nv = r.operand_value;
          rsp.ok = 1'b1;
        end
      end
    endcase
    shadow_cells[r.cell_index] = nv;
    rsp.count = nv;
    return rsp;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    errors++;
    if (errors <= MAX_REPORTS)
      $display("%0t: %s: got %0d, expected %0d", $realtime, what, got, want);
  endtask

  task automatic push_req(input logic [OP_W-1:0] op, input int unsigned idx,
                          input int unsigned val);
    counter_req_t r;
    r.opcode = op;
    r.cell_index = CELL_IDX_W'(idx);
    r.operand_value = VAL_W'(val);
    request_queue.push_back(r);
  endtask

  function automatic logic [VAL_W-1:0] near_max(logic [CNT_W-1:0] maxv);
    int v;
    v = int'(maxv) + int'($urandom_range(4)) - 2;
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return VAL_W'(v);
  endfunction

  task automatic push_random_req();
    logic [OP_W-1:0]  op;
    logic [CNT_W-1:0] maxv;
    int unsigned      pick;
    int unsigned      idx;
    int unsigned      val;
    maxv = width_max(width_setting);
    pick = $urandom_range(999);
    if (pick < 10) op = OP_CLEAR;
    else if (pick < 60) op = OP_W'(OP_RSVD5 + $urandom_range(2));
    else if (pick < 360) op = OP_INC;
    else if (pick < 560) op = OP_DEC;
    else if (pick < 760) op = OP_READ;
    else op = OP_SET;
    pick = $urandom_range(99);
    if (pick < 70) idx = $urandom_range(15);
    else if (pick < 80) idx = $urandom_range(1) ? NUM_CELLS - 1 : 0;
    else idx = $urandom_range(NUM_CELLS - 1);
    pick = $urandom_range(99);
    val = $urandom_range(65535);
    if (op == OP_INC) begin
      if (pick < 40) val = $urandom_range(3);
      else if (pick < 70) val = near_max(maxv);
    end else if (op == OP_SET) begin
      if (pick < 50) val = $urandom_range(maxv);
      else if (pick < 75) val = near_max(maxv);
    end
    push_req(op, idx, val);
  endtask

  task automatic wait_until_idle();
    while (request_queue.size() != 0 || in_if.valid || predicted_rsps.size() != 0)
      @(posedge clk);
    repeat (NUM_CELLS + 16) @(posedge clk);
  endtask

  task automatic write_width(input logic [CFG_W-1:0] w);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= w;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    width_setting = w;
  endtask

  // Request driver: predicts each request as it is accepted.
  always @(posedge clk) begin
    counter_req_t next_req;
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        predicted_rsps.push_back(apply_counter_op({in_if.opcode, in_if.cell_index,
                                                   in_if.operand_value}));
        accepted_reqs <= accepted_reqs + 1;
      end
      if (!in_if.valid || in_if.ready) begin
        if (request_queue.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          next_req = request_queue.pop_front();
          in_if.valid <= 1'b1;
          in_if.opcode <= next_req.opcode;
          in_if.cell_index <= next_req.cell_index;
          in_if.operand_value <= next_req.operand_value;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // One long stretch with the receiver held off, so the block backs up.
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && accepted_reqs == HOLD_AT_REQ) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin
    counter_rsp_t want;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (predicted_rsps.size() == 0) begin
          report_mismatch("result with no request pending", out_if.count_out, 0);
        end else begin
          want = predicted_rsps.pop_front();
          if (out_if.count_out !== want.count)
            report_mismatch("count_out", out_if.count_out, want.count);
          if (out_if.ok !== want.ok)
            report_mismatch("ok", out_if.ok, want.ok);
        end
      end
      out_if.ready <= (hold_left == 0) && ($urandom_range(99) >= rx_idle_pct);
    end
  end

  initial begin
    logic [CFG_W-1:0] phase_widths[9];
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = WIDTH_RESET;
    in_if.valid = 1'b0;
    in_if.opcode = OP_READ;
    in_if.cell_index = '0;
    in_if.operand_value = '0;
    out_if.ready = 1'b0;
    foreach (shadow_cells[i]) shadow_cells[i] = '0;
    phase_widths = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd7, 5'd17, 5'd2, 5'd12, 5'd0};
    phase_widths[8] = CFG_W'($urandom_range(31));
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    push_req(OP_INC, 0, 0);
    push_req(OP_INC, 0, 5);
    push_req(OP_INC, 0, 15);
    push_req(OP_INC, 0, 15);
    push_req(OP_INC, 0, 65535);
    push_req(OP_SET, 1, 10);
    push_req(OP_INC, 1, 8);
    push_req(OP_DEC, 2, 0);
    push_req(OP_DEC, 0, 65535);
    push_req(OP_READ, NUM_CELLS - 1, 0);
    push_req(OP_SET, NUM_CELLS - 1, 65535);
    push_req(OP_SET, NUM_CELLS - 1, 16);
    push_req(OP_SET, NUM_CELLS - 1, 15);
    push_req(OP_READ, NUM_CELLS - 1, 65535);
    push_req(OP_RSVD5, NUM_CELLS - 1, 65535);
    push_req(OP_RSVD6, 0, 0);
    push_req(OP_RSVD7, 1, 21845);
    push_req(OP_CLEAR, NUM_CELLS - 1, 65535);
    push_req(OP_READ, 0, 0);
    push_req(OP_READ, NUM_CELLS - 1, 0);
    push_req(OP_INC, 1, 0);
    wait_until_idle();

    for (int p = 0; p < 9; p++) begin
      if (p == 3) begin
        tx_idle_pct <= 83;
        rx_idle_pct <= 26;
      end else if (p == 6) begin
        tx_idle_pct <= 0;
        rx_idle_pct <= 0;
      end
      write_width(phase_widths[p]);
      for (int n = 0; n < PHASE_REQS; n++) push_random_req();
      wait_until_idle();
    end

    if (predicted_rsps.size() != 0)
      report_mismatch("results never delivered", 0, predicted_rsps.size());
    if (errors == 0) begin
      $display("saturating_counter_array: match");
    end else begin
      $display("saturating_counter_array: mismatch");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("saturating_counter_array: mismatch");
    $finish;
  end

endmodule

FILE: files.f
rtl/sca_pkg.sv
rtl/sca_if.sv
rtl/saturating_counter_array.sv
dv/saturating_counter_array_test.sv
